/* src/lph_pkg.sv */
// Package for the linear-probe hash table: field widths, slot states,
// operation and result codes, and the layout of one table entry.
// No dependencies.
package lph_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned KeyMagW      = KeyW - 1;
  localparam int unsigned TagW         = 64;
  localparam int unsigned CodeW        = 3;
  localparam int unsigned SlotW        = 4;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_GONE  = 2'd2
  } lph_slot_e;

  typedef enum logic [ModeW-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } lph_mode_e;

  typedef enum logic [CodeW-1:0] {
    RC_DONE       = 3'd0,
    RC_NOT_FOUND  = 3'd1,
    RC_PRESENT    = 3'd2,
    RC_OTHER_NAME = 3'd3,
    RC_FULL       = 3'd4,
    RC_BAD_KEY    = 3'd5
  } lph_code_e;

  typedef struct packed {
    lph_slot_e         state;
    logic [KeyW-1:0]   key;
    logic [TagW-1:0]   name;
  } lph_entry_t;

  localparam int unsigned EntryW = $bits(lph_entry_t);

endpackage

/* src/lph_if.sv */
// Valid/ready channel interfaces for the hash table request and response words.
// Depends on lph_pkg.
interface lph_in_if import lph_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       mode;
  logic signed [KeyW-1:0] key;
  logic [TagW-1:0]        name_tag;

  modport source (output valid, mode, key, name_tag, input ready);
  modport sink   (input valid, mode, key, name_tag, output ready);
endinterface

interface lph_out_if import lph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CodeW-1:0]  result_code;
  logic [SlotW-1:0]  slot_index;

  modport source (output valid, result_code, slot_index, input ready);
  modport sink   (input valid, result_code, slot_index, output ready);
endinterface

/* src/linear_probe_hash_table.sv */
// Top level of the linear-probe hash table: probe sequencer, table memory
// and home slot unit. Depends on lph_pkg, lph_if, lph_ram and lph_mod.
//
//  channel  dir  word                         handshake
//  in_i     in   mode, key, name_tag          valid/ready
//  out_o    out  result_code, slot_index      valid/ready
//
// After reset every slot is written empty in turn, with in_i.ready low.
// An operation hashes the key to a home slot, by a mask for a power-of-two slot
// count, else by a reciprocal multiply, then correction, and then probes from 1
// to Slots slots, one memory read a cycle. Negative keys and unused modes skip
// hashing and probing. in_i.ready is high only between operations; a result waiting on
// out_o does not block the next request until a second result is ready.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lph_in_if.sink    in_i,
  lph_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(Slots);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW:0]     n_q, n_d;
  logic [IdxW-1:0]   free_q, free_d;
  logic              free_vld_q, free_vld_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [TagW-1:0]   tag_q, tag_d;
  lph_code_e         code_q, code_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              out_vld_q, out_vld_d;
  logic [CodeW-1:0]  out_code_q, out_code_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;

  logic              accept;
  logic              hash_busy;
  logic [IdxW-1:0]   hash_rem;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  lph_entry_t        ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  lph_entry_t        ent;
  logic              is_hit;
  logic              is_free;
  logic              walk_end;
  logic              name_eq;
  logic [IdxW-1:0]   ins_slot;

  assign accept = in_i.valid && in_i.ready;
  assign ent    = lph_entry_t'(ram_rdata);

  lph_mod #(
    .Slots(Slots)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (in_i.key[KeyMagW-1:0]),
    .busy_o     (hash_busy),
    .rem_o      (hash_rem)
  );

  lph_ram #(
    .Width(EntryW),
    .Depth(Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    n_d        = n_q;
    free_d     = free_q;
    free_vld_d = free_vld_q;
    mode_d     = mode_q;
    key_d      = key_q;
    tag_d      = tag_q;
    code_d     = code_q;
    slot_d     = slot_q;
    out_vld_d  = out_vld_q;
    out_code_d = out_code_q;
    out_slot_d = out_slot_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q;
    ram_wdata  = '{state: ST_EMPTY, key: '0, name: '0};

    is_hit   = (ent.state == ST_USED) && (ent.key == key_q);
    is_free  = (ent.state != ST_USED);
    walk_end = (ent.state == ST_EMPTY) || (n_q == (IdxW + 1)'(Slots - 1));
    name_eq  = (ent.name == tag_q);
    ins_slot = free_vld_q ? free_q : cur_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cur_q == IdxW'(Slots - 1)) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d = in_i.mode;
          key_d  = in_i.key;
          tag_d  = in_i.name_tag;
          slot_d = '0;
          if (in_i.mode == MODE_INSERT && in_i.key[KeyW-1]) begin
            code_d  = RC_BAD_KEY;
            state_d = S_FINISH;
          end else if (in_i.key[KeyW-1] || !(in_i.mode inside
                       {MODE_LOOKUP, MODE_INSERT, MODE_DELETE})) begin
            code_d  = RC_NOT_FOUND;
            state_d = S_FINISH;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (!hash_busy) begin
          cur_d      = hash_rem;
          n_d        = '0;
          free_vld_d = 1'b0;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (is_hit) begin
          state_d = S_FINISH;
          slot_d  = SlotW'(cur_q);
          case (mode_q)
            MODE_LOOKUP: code_d = name_eq ? RC_DONE : RC_OTHER_NAME;
            MODE_INSERT: code_d = name_eq ? RC_PRESENT : RC_OTHER_NAME;
            default: begin
              if (name_eq) begin
                code_d    = RC_DONE;
                ram_we    = 1'b1;
                ram_wdata = '{state: ST_GONE, key: key_q, name: tag_q};
              end else begin
                code_d = RC_NOT_FOUND;
                slot_d = '0;
              end
            end
          endcase
        end else if (walk_end) begin
          state_d = S_FINISH;
          slot_d  = '0;
          code_d  = RC_NOT_FOUND;
          if (mode_q == MODE_INSERT) begin
            if (free_vld_q || is_free) begin
              code_d    = RC_DONE;
              slot_d    = SlotW'(ins_slot);
              ram_we    = 1'b1;
              ram_waddr = ins_slot;
              ram_wdata = '{state: ST_USED, key: key_q, name: tag_q};
            end else begin
              code_d = RC_FULL;
            end
          end
        end else begin
          if (is_free && !free_vld_q) begin
            free_d     = cur_q;
            free_vld_d = 1'b1;
          end
          n_d   = n_q + 1'b1;
          cur_d = (cur_q == IdxW'(Slots - 1)) ? '0 : cur_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_code_d = code_q;
          out_slot_d = slot_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_q      <= '0;
      n_q        <= '0;
      free_q     <= '0;
      free_vld_q <= 1'b0;
      mode_q     <= '0;
      key_q      <= '0;
      tag_q      <= '0;
      code_q     <= RC_NOT_FOUND;
      slot_q     <= '0;
      out_vld_q  <= 1'b0;
      out_code_q <= '0;
      out_slot_q <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      n_q        <= n_d;
      free_q     <= free_d;
      free_vld_q <= free_vld_d;
      mode_q     <= mode_d;
      key_q      <= key_d;
      tag_q      <= tag_d;
      code_q     <= code_d;
      slot_q     <= slot_d;
      out_vld_q  <= out_vld_d;
      out_code_q <= out_code_d;
      out_slot_q <= out_slot_d;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.result_code = out_code_q;
  assign out_o.slot_index  = out_slot_q;

endmodule

/* src/lph_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lph_mod.sv */
// Home slot unit: key modulo the slot count by a reciprocal multiply and one
// correction step, or a plain mask when the slot count is a power of two.
// Depends on lph_pkg.
module lph_mod import lph_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault,
  localparam int unsigned IdxW = $clog2(Slots)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [KeyMagW-1:0] dividend_i,
  output logic               busy_o,
  output logic [IdxW-1:0]    rem_o
);

  localparam bit                IsPow2 = ((Slots & (Slots - 1)) == 0);
  localparam int unsigned       Shift  = KeyMagW + IdxW;
  localparam int unsigned       RecipW = KeyW;
  localparam int unsigned       ProdW  = KeyMagW + RecipW;
  localparam int unsigned       LowW   = IdxW + 1;
  localparam logic [RecipW-1:0] Recip  = RecipW'((64'd1 << Shift) / 64'(Slots));

  logic               busy_q, busy_d;
  logic               phase_q, phase_d;
  logic [KeyMagW-1:0] div_q, div_d;
  logic [LowW-1:0]    qlo_q, qlo_d;
  logic [IdxW-1:0]    rem_q, rem_d;
  logic [ProdW-1:0]   prod;
  logic [LowW-1:0]    qd_lo;
  logic [LowW-1:0]    diff;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    div_d   = div_q;
    qlo_d   = qlo_q;
    rem_d   = rem_q;
    prod    = ProdW'(div_q) * ProdW'(Recip);
    qd_lo   = qlo_q * LowW'(Slots);
    diff    = div_q[LowW-1:0] - qd_lo;
    if (start_i) begin
      div_d   = dividend_i;
      phase_d = 1'b0;
      if (IsPow2) begin
        rem_d  = dividend_i[IdxW-1:0];
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!phase_q) begin
        qlo_d   = prod[Shift +: LowW];
        phase_d = 1'b1;
      end else begin
        if (diff >= LowW'(Slots)) begin
          rem_d = IdxW'(diff - LowW'(Slots));
        end else begin
          rem_d = IdxW'(diff);
        end
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      div_q   <= '0;
      qlo_q   <= '0;
      rem_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      div_q   <= div_d;
      qlo_q   <= qlo_d;
      rem_q   <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

/* verif/linear_probe_hash_table_tb.sv */
// Testbench for linear_probe_hash_table: directed and randomized lookup, insert and
// delete words, checked against a scoreboard that keeps its own copy of the table.
// Depends on lph_pkg, lph_if and the RTL of the block.
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lph_pkg::*;

  localparam int unsigned Slots = SlotsDefault;
  localparam int unsigned PoolSize = 20;
  localparam int unsigned Rounds = 14;
  localparam int unsigned FillWords = 20;
  localparam int unsigned MixWords = 62;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned MaxReports = 100;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    lph_code_e         code;
    logic [SlotW-1:0]  slot;
  } lph_answer_t;

  class lph_table_scoreboard;
    logic [KeyW-1:0]  slot_key   [Slots];
    logic [TagW-1:0]  slot_name  [Slots];
    lph_slot_e        slot_state [Slots];
    lph_answer_t      pending_answers [$];
    int               mismatches;

    function new();
      foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
      mismatches = 0;
    endfunction

    task report(string what);
      if (mismatches < MaxReports) $display("mismatch: %s", what);
      mismatches++;
    endtask

    function int find_key(logic [KeyW-1:0] k);
      int unsigned idx;
      idx = k % Slots;
      for (int n = 0; n < Slots; n++) begin
        if (slot_state[idx] == ST_EMPTY) return -1;
        if (slot_state[idx] == ST_USED && slot_key[idx] == k) return idx;
        idx = (idx + 1) % Slots;
      end
      return -1;
    endfunction

    function void note_request(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                               logic [TagW-1:0] tag);
      lph_answer_t ans;
      int hit;
      int unsigned idx;
      ans.code = RC_NOT_FOUND;
      ans.slot = '0;
      if (mode == MODE_LOOKUP || mode == MODE_DELETE) begin
        if (!key[KeyW-1]) begin
          hit = find_key(key);
          if (hit >= 0) begin
            if (slot_name[hit] == tag) begin
              ans.code = RC_DONE;
              ans.slot = hit[SlotW-1:0];
              if (mode == MODE_DELETE) slot_state[hit] = ST_GONE;
            end else if (mode == MODE_LOOKUP) begin
              ans.code = RC_OTHER_NAME;
              ans.slot = hit[SlotW-1:0];
            end
          end
        end
      end else if (mode == MODE_INSERT) begin
        if (key[KeyW-1]) begin
          ans.code = RC_BAD_KEY;
        end else begin
          hit = find_key(key);
          if (hit >= 0) begin
            ans.code = (slot_name[hit] == tag) ? RC_PRESENT : RC_OTHER_NAME;
            ans.slot = hit[SlotW-1:0];
          end else begin
            ans.code = RC_FULL;
            idx = key % Slots;
            for (int n = 0; n < Slots; n++) begin
              if (slot_state[idx] != ST_USED) begin
                slot_key[idx]   = key;
                slot_name[idx]  = tag;
                slot_state[idx] = ST_USED;
                ans.code = RC_DONE;
                ans.slot = idx[SlotW-1:0];
                break;
              end
              idx = (idx + 1) % Slots;
            end
          end
        end
      end
      pending_answers.push_back(ans);
    endfunction

    task check_response(logic [CodeW-1:0] code, logic [SlotW-1:0] slot);
      lph_answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected word code %0d slot %0d", code, slot));
        return;
      end
      want = pending_answers.pop_front();
      if (code !== want.code)
        report($sformatf("result_code %0d, want %0d", code, want.code));
      if (slot !== want.slot)
        report($sformatf("slot_index %0d, want %0d", slot, want.slot));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  lph_in_if  in_bus ();
  lph_out_if out_bus ();

  linear_probe_hash_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  lph_table_scoreboard table_sb;
  bit steady_sender;
  bit hold_outputs;
  int unsigned results_taken;
  logic [KeyW-1:0] pool_key [PoolSize];
  logic [TagW-1:0] pool_tag [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("linear_probe_hash_table_tb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        table_sb.note_request(in_bus.mode, in_bus.key, in_bus.name_tag);
      if (out_bus.valid && out_bus.ready) begin
        table_sb.check_response(out_bus.result_code, out_bus.slot_index);
        results_taken++;
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_outputs) begin
        wait_cycles = HoldCycles;
        hold_outputs = 1'b0;
      end else if ((results_taken / 64) % 3 == 0) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 14);
      end
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  task automatic offer_word(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                            logic [TagW-1:0] tag);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= mode;
    in_bus.key      <= key;
    in_bus.name_tag <= tag;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic drain_answers();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (table_sb.pending_answers.size() != 0);
  endtask

  // drop every live entry so the next round starts from tombstones
  task automatic clear_table();
    logic [KeyW-1:0] keys [$];
    logic [TagW-1:0] tags [$];
    drain_answers();
    foreach (table_sb.slot_state[i]) begin
      if (table_sb.slot_state[i] == ST_USED) begin
        keys.push_back(table_sb.slot_key[i]);
        tags.push_back(table_sb.slot_name[i]);
      end
    end
    foreach (keys[i]) offer_word(MODE_DELETE, keys[i], tags[i]);
    drain_answers();
  endtask

  function automatic logic [TagW-1:0] random_tag();
    return {$urandom, $urandom};
  endfunction

  task automatic refresh_pool(int unsigned round);
    logic [KeyW-1:0] mask;
    int unsigned cluster;
    mask = (round % 2 == 1) ? 32'h7FFF_FFF0 : 32'h0000_00F0;
    cluster = $urandom_range(3, Slots - 1);
    foreach (pool_key[i]) begin
      pool_key[i] = ($urandom & mask) | $urandom_range(0, cluster);
      pool_tag[i] = random_tag();
    end
  endtask

  task automatic mixed_word();
    int unsigned pick;
    int unsigned idx;
    int unsigned sel;
    logic [ModeW-1:0] mode;
    logic [TagW-1:0] tag;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    mode = (sel < 40) ? MODE_INSERT : (sel < 75) ? MODE_LOOKUP : MODE_DELETE;
    if (pick < 3) begin
      offer_word(mode, {1'b1, 31'($urandom)}, random_tag());
    end else if (pick < 6) begin
      offer_word(ModeUnused, $urandom, random_tag());
    end else if (pick < 11) begin
      offer_word(mode, {1'b0, 31'($urandom)}, random_tag());
    end else begin
      idx = $urandom_range(0, PoolSize - 1);
      sel = $urandom_range(0, 9);
      if (sel < 8) tag = pool_tag[idx];
      else if (sel == 8) tag = random_tag();
      else tag = pool_tag[$urandom_range(0, PoolSize - 1)];
      offer_word(mode, pool_key[idx], tag);
    end
  endtask

  initial begin
    table_sb = new();
    steady_sender = 1'b0;
    hold_outputs = 1'b0;
    results_taken = 0;
    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= MODE_LOOKUP;
    in_bus.key <= '0;
    in_bus.name_tag <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_word(MODE_LOOKUP, 32'd0, '1);
    offer_word(MODE_INSERT, 32'd0, '1);
    offer_word(MODE_INSERT, 32'd0, '1);
    offer_word(MODE_INSERT, 32'd0, '0);
    offer_word(MODE_LOOKUP, 32'd0, '1);
    offer_word(MODE_LOOKUP, 32'd0, '0);
    offer_word(MODE_DELETE, 32'd0, '0);
    offer_word(MODE_INSERT, 32'd16, 64'hA5A5_A5A5_A5A5_A5A5);
    offer_word(MODE_INSERT, 32'h7FFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A);
    offer_word(MODE_INSERT, 32'd31, 64'hA5A5_A5A5_A5A5_A5A5);
    offer_word(MODE_LOOKUP, 32'd31, 64'hA5A5_A5A5_A5A5_A5A5);
    offer_word(MODE_INSERT, 32'h8000_0000, '1);
    offer_word(MODE_LOOKUP, 32'hFFFF_FFFF, '1);
    offer_word(MODE_DELETE, 32'h8000_0001, '1);
    offer_word(ModeUnused, 32'd0, '1);
    offer_word(MODE_DELETE, 32'd0, '1);
    offer_word(MODE_LOOKUP, 32'd16, 64'hA5A5_A5A5_A5A5_A5A5);
    offer_word(MODE_LOOKUP, 32'd0, '1);
    offer_word(MODE_INSERT, 32'd32, '0);
    offer_word(MODE_DELETE, 32'h7FFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A);
    offer_word(MODE_LOOKUP, 32'd31, 64'hA5A5_A5A5_A5A5_A5A5);
    clear_table();

    for (int unsigned round = 0; round < Rounds; round++) begin
      steady_sender = (round % 3 == 1);
      refresh_pool(round);
      for (int unsigned i = 0; i < FillWords; i++)
        offer_word(MODE_INSERT, pool_key[i], pool_tag[i]);
      if (round == 3) begin
        steady_sender = 1'b1;
        hold_outputs = 1'b1;
      end
      for (int unsigned i = 0; i < MixWords; i++) mixed_word();
      clear_table();
    end

    drain_answers();
    repeat (4 * Slots) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.pending_answers.size() == 0) begin
      $display("linear_probe_hash_table_tb: PASS");
    end else begin
      $display("linear_probe_hash_table_tb: FAIL");
    end
    $finish;
  end

endmodule
